[hw/rtl/key_matrix_to_hid_report_top_assert.svh]
// assertion macros shared by the keyboard report block
// each macro expects clk and rst_n in scope
`ifndef KEY_MATRIX_TO_HID_REPORT_TOP_ASSERT_SVH
`define KEY_MATRIX_TO_HID_REPORT_TOP_ASSERT_SVH

// same-cycle implication
`define KMHR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmhr assertion failed");

// next-cycle implication
`define KMHR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmhr assertion failed");

`endif

[hw/rtl/kmhr_pkg.sv]
package kmhr_pkg;

    localparam int ROWS       = 5;
    localparam int COLS       = 14;
    localparam int KEY_SLOTS  = 6;
    localparam int OUT_KEYS   = 6;
    localparam int LEVEL_BITS = 14;
    localparam int MOD_FIRST  = 224;
    localparam int MOD_LAST   = 230;

    localparam int MAP_DEPTH  = ROWS * COLS;
    localparam int MAP_AW     = $clog2(MAP_DEPTH);
    localparam int COL_LIM    = (COLS < LEVEL_BITS) ? COLS : LEVEL_BITS;

    localparam int ROW_W      = 3;
    localparam int COL_W      = 4;
    localparam int CODE_W     = 8;
    localparam int MOD_W      = 7;
    localparam int SLOT_W     = $clog2(KEY_SLOTS + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_SCAN  = 1'b1;

    localparam logic [ROW_W-1:0] ROW_COUNT_RST = 3'd5;
    localparam logic [COL_W-1:0] COL_COUNT_RST = 4'd14;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic map_write;
        logic scan_start;
        logic walk;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_scan;
        logic row_ok;
        logic walk_done;
        logic is_last;
        logic need_emit;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/kmhr_ram.sv]
module kmhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/kmhr_ctrl.sv]
module kmhr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kmhr_pkg::status_t status,
    output kmhr_pkg::cmd_t    cmd
);

    `include "key_matrix_to_hid_report_top_assert.svh"

    kmhr_pkg::state_t state_reg;
    kmhr_pkg::state_t state_next;
    logic             accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmhr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.map_write  = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.walk       = 1'b0;
        cmd.emit       = 1'b0;
        case (state_reg)
            kmhr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (!status.in_scan)
                    begin
                        cmd.map_write = 1'b1;
                    end
                    else if (status.row_ok)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = kmhr_pkg::ST_WALK;
                    end
                end
            end
            kmhr_pkg::ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    state_next = kmhr_pkg::ST_FINISH;
                end
            end
            kmhr_pkg::ST_FINISH:
            begin
                // hold here while the previous report is still waiting
                if (status.is_last && status.need_emit)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = kmhr_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = kmhr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kmhr_pkg::ST_IDLE;
            end
        endcase
    end

    `KMHR_ASSERT_NXT(a_scan_enters_walk, cmd.scan_start, state_reg == kmhr_pkg::ST_WALK)
    `KMHR_ASSERT_NXT(a_walk_ends_in_finish, (state_reg == kmhr_pkg::ST_WALK) && status.walk_done,
                     state_reg == kmhr_pkg::ST_FINISH)

endmodule

[hw/rtl/kmhr_datapath.sv]
module kmhr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kmhr_pkg::cmd_t                      cmd,
    output kmhr_pkg::status_t                   status,
    input  logic                                cfg_we,
    input  logic [kmhr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kmhr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                kind,
    input  logic [kmhr_pkg::ROW_W-1:0]          row,
    input  logic [kmhr_pkg::COL_W-1:0]          col,
    input  logic [kmhr_pkg::CODE_W-1:0]         keycode,
    input  logic [kmhr_pkg::LEVEL_BITS-1:0]     col_levels,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [kmhr_pkg::MOD_W-1:0]          out_mod,
    output logic [kmhr_pkg::CODE_W-1:0]         out_keys [kmhr_pkg::OUT_KEYS]
);

    `include "key_matrix_to_hid_report_top_assert.svh"

    // configuration
    logic [kmhr_pkg::ROW_W-1:0]  row_count_reg;
    logic [kmhr_pkg::COL_W-1:0]  col_count_reg;
    logic [kmhr_pkg::ROW_W-1:0]  rows_eff;
    logic [kmhr_pkg::COL_W-1:0]  cols_eff;

    // keymap storage and per-entry written flags
    logic [kmhr_pkg::MAP_DEPTH-1:0] map_valid_reg;
    logic                           wr_ok;
    logic [kmhr_pkg::MAP_AW-1:0]    wr_addr;
    logic [kmhr_pkg::MAP_AW-1:0]    rd_addr;
    logic                           rd_en;
    logic [kmhr_pkg::CODE_W-1:0]    ram_q;

    // current row
    logic [kmhr_pkg::ROW_W-1:0]      scan_row_reg;
    logic [kmhr_pkg::LEVEL_BITS-1:0] levels_reg;
    logic [kmhr_pkg::COL_W-1:0]      col_idx_reg;

    // lookup stage
    logic                        ev_valid_reg;
    logic                        ev_pressed_reg;
    logic                        ev_mapped_reg;
    logic [kmhr_pkg::CODE_W-1:0] ev_code;
    logic [kmhr_pkg::CODE_W-1:0] mod_off;
    logic                        is_mod;

    // accumulators
    logic [kmhr_pkg::MOD_W-1:0]  mod_acc_reg;
    logic [kmhr_pkg::MOD_W-1:0]  mod_acc_next;
    logic [kmhr_pkg::CODE_W-1:0] slots_reg  [kmhr_pkg::KEY_SLOTS];
    logic [kmhr_pkg::CODE_W-1:0] slots_next [kmhr_pkg::KEY_SLOTS];
    logic [kmhr_pkg::SLOT_W-1:0] slot_count_reg;
    logic [kmhr_pkg::SLOT_W-1:0] slot_count_next;
    logic                        any_pressed_reg;
    logic                        any_pressed_next;
    logic                        prev_pressed_reg;

    // report register
    logic                        out_valid_reg;
    logic [kmhr_pkg::MOD_W-1:0]  out_mod_reg;
    logic [kmhr_pkg::CODE_W-1:0] out_keys_reg [kmhr_pkg::OUT_KEYS];

    always_comb
    begin
        rows_eff = row_count_reg;
        if (row_count_reg == '0)
        begin
            rows_eff = kmhr_pkg::ROW_W'(1);
        end
        else if (row_count_reg > kmhr_pkg::ROW_W'(kmhr_pkg::ROWS))
        begin
            rows_eff = kmhr_pkg::ROW_W'(kmhr_pkg::ROWS);
        end
        cols_eff = col_count_reg;
        if (col_count_reg > kmhr_pkg::COL_W'(kmhr_pkg::COL_LIM))
        begin
            cols_eff = kmhr_pkg::COL_W'(kmhr_pkg::COL_LIM);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= kmhr_pkg::ROW_COUNT_RST;
            col_count_reg <= kmhr_pkg::COL_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kmhr_pkg::REG_ROW_COUNT: row_count_reg <= cfg_data[kmhr_pkg::ROW_W-1:0];
                kmhr_pkg::REG_COL_COUNT: col_count_reg <= cfg_data[kmhr_pkg::COL_W-1:0];
                default:                 row_count_reg <= row_count_reg;
            endcase
        end
    end

    assign wr_ok   = (32'(row) < kmhr_pkg::ROWS) && (32'(col) < kmhr_pkg::COLS);
    assign wr_addr = kmhr_pkg::MAP_AW'(32'(row) * kmhr_pkg::COLS + 32'(col));
    assign rd_addr = kmhr_pkg::MAP_AW'(32'(scan_row_reg) * kmhr_pkg::COLS + 32'(col_idx_reg));
    assign rd_en   = cmd.walk && !status.walk_done;

    kmhr_ram #(
        .WIDTH (kmhr_pkg::CODE_W),
        .DEPTH (kmhr_pkg::MAP_DEPTH)
    ) u_keymap (
        .clk   (clk),
        .we    (cmd.map_write && wr_ok),
        .waddr (wr_addr),
        .wdata (keycode),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= '0;
        end
        else if (cmd.map_write && wr_ok)
        begin
            map_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // column walk, one keymap read per column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_idx_reg  <= '0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg <= rd_en;
            if (cmd.scan_start)
            begin
                col_idx_reg <= '0;
            end
            else if (rd_en)
            begin
                col_idx_reg <= col_idx_reg + kmhr_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_row_reg <= row;
            levels_reg   <= col_levels;
        end
        if (rd_en)
        begin
            ev_pressed_reg <= !levels_reg[col_idx_reg];
            ev_mapped_reg  <= map_valid_reg[rd_addr];
        end
    end

    // never-written entries read as zero
    assign ev_code = ev_mapped_reg ? ram_q : '0;
    assign mod_off = ev_code - kmhr_pkg::CODE_W'(kmhr_pkg::MOD_FIRST);
    assign is_mod  = (ev_code >= kmhr_pkg::CODE_W'(kmhr_pkg::MOD_FIRST))
                  && (ev_code <= kmhr_pkg::CODE_W'(kmhr_pkg::MOD_LAST));

    always_comb
    begin
        mod_acc_next     = mod_acc_reg;
        slots_next       = slots_reg;
        slot_count_next  = slot_count_reg;
        any_pressed_next = any_pressed_reg;
        if (cmd.scan_start && (row == '0))
        begin
            mod_acc_next     = '0;
            slot_count_next  = '0;
            any_pressed_next = 1'b0;
            for (int k = 0; k < kmhr_pkg::KEY_SLOTS; k++)
            begin
                slots_next[k] = '0;
            end
        end
        else if (ev_valid_reg && ev_pressed_reg
                 && (slot_count_reg < kmhr_pkg::SLOT_W'(kmhr_pkg::KEY_SLOTS)))
        begin
            any_pressed_next = 1'b1;
            if (is_mod)
            begin
                mod_acc_next = mod_acc_reg | (kmhr_pkg::MOD_W'(1) << mod_off[2:0]);
            end
            else
            begin
                for (int k = 0; k < kmhr_pkg::KEY_SLOTS; k++)
                begin
                    if (slot_count_reg == kmhr_pkg::SLOT_W'(k))
                    begin
                        slots_next[k] = ev_code;
                    end
                end
                slot_count_next = slot_count_reg + kmhr_pkg::SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_acc_reg      <= '0;
            slot_count_reg   <= '0;
            any_pressed_reg  <= 1'b0;
            prev_pressed_reg <= 1'b0;
            for (int k = 0; k < kmhr_pkg::KEY_SLOTS; k++)
            begin
                slots_reg[k] <= '0;
            end
        end
        else
        begin
            mod_acc_reg     <= mod_acc_next;
            slots_reg       <= slots_next;
            slot_count_reg  <= slot_count_next;
            any_pressed_reg <= any_pressed_next;
            if (cmd.emit)
            begin
                prev_pressed_reg <= any_pressed_reg;
            end
        end
    end

    // report output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_mod_reg <= mod_acc_reg;
            for (int k = 0; k < kmhr_pkg::OUT_KEYS; k++)
            begin
                out_keys_reg[k] <= (k < kmhr_pkg::KEY_SLOTS) ? slots_reg[k] : '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_mod   = out_mod_reg;
    assign out_keys  = out_keys_reg;

    assign status.in_scan   = (kind == kmhr_pkg::KIND_SCAN);
    assign status.row_ok    = (row < rows_eff);
    assign status.walk_done = (col_idx_reg >= cols_eff);
    assign status.is_last   = (scan_row_reg == rows_eff - kmhr_pkg::ROW_W'(1));
    assign status.need_emit = any_pressed_reg || prev_pressed_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    `KMHR_ASSERT_IMP(a_emit_into_free_slot, cmd.emit, !out_valid_reg || out_ready)
    `KMHR_ASSERT_IMP(a_lookup_follows_walk, ev_valid_reg, $past(cmd.walk))

endmodule

[hw/rtl/key_matrix_to_hid_report_top.sv]
// keyboard matrix to hid boot report: each input word is either a keymap write
// (kind 0: keycode stored at row, col) or one scanned matrix row (kind 1,
// col_levels active low). rows of a scan come in order, row 0 clears the
// accumulated report. pressed columns below col_count are looked up in the
// keymap; codes 224..230 set modifier bits, any other code fills the next of six
// key slots, and once six slots are full the rest of the scan is ignored.
// on the last row (row_count - 1) a report word is sent if a key was pressed,
// or one empty report after a release. a scan row is limited by the single
// keymap read port, which walks one column per cycle. a report waits in an
// output register so the next word is taken meanwhile; a scan finishing while
// a report is still untaken holds until it drains. the keymap reads as zero
// until an entry is written, tracked by per-entry flags, so no clearing pass
// is needed. the user must write configuration only while idle; the block
// itself does not enforce this
module key_matrix_to_hid_report_top (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration
    input  logic                            cfg_we,
    input  logic [kmhr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kmhr_pkg::CFG_DATA_W-1:0] cfg_data,

    // input words
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [kmhr_pkg::ROW_W-1:0]      row,
    input  logic [kmhr_pkg::COL_W-1:0]      col,
    input  logic [kmhr_pkg::CODE_W-1:0]     keycode,
    input  logic [kmhr_pkg::LEVEL_BITS-1:0] col_levels,

    // report words
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [kmhr_pkg::MOD_W-1:0]      modifiers,
    output logic [kmhr_pkg::CODE_W-1:0]     key0,
    output logic [kmhr_pkg::CODE_W-1:0]     key1,
    output logic [kmhr_pkg::CODE_W-1:0]     key2,
    output logic [kmhr_pkg::CODE_W-1:0]     key3,
    output logic [kmhr_pkg::CODE_W-1:0]     key4,
    output logic [kmhr_pkg::CODE_W-1:0]     key5
);

    kmhr_pkg::cmd_t              cmd;
    kmhr_pkg::status_t           status;
    logic [kmhr_pkg::CODE_W-1:0] keys [kmhr_pkg::OUT_KEYS];

    // sequencing: idle, column walk, report decision
    kmhr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // keymap, accumulators and report register
    kmhr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .row        (row),
        .col        (col),
        .keycode    (keycode),
        .col_levels (col_levels),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_mod    (modifiers),
        .out_keys   (keys)
    );

    // key slots in scan order
    assign key0 = keys[0];
    assign key1 = keys[1];
    assign key2 = keys[2];
    assign key3 = keys[3];
    assign key4 = keys[4];
    assign key5 = keys[5];

endmodule
